// File: rtl/e2r_pkg.sv
`timescale 1ns / 1ps
package e2r_pkg;

  localparam int AngleWidth  = 16;
  localparam int EntryWidth  = 16;
  localparam int CordicSteps = 30;
  localparam int StepIdxW    = 5;
  // internal CORDIC width: Q30 values up to about +-2^32 plus headroom
  localparam int CordW       = 36;

  localparam logic signed [CordW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [CordW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [CordW-1:0] GainQ30   = 36'sd652032874;

  typedef struct packed {
    logic signed [AngleWidth-1:0] angle_x;
    logic signed [AngleWidth-1:0] angle_y;
    logic signed [AngleWidth-1:0] angle_z;
  } in_word_t;

  typedef struct packed {
    logic signed [EntryWidth-1:0] r11;
    logic signed [EntryWidth-1:0] r12;
    logic signed [EntryWidth-1:0] r13;
    logic signed [EntryWidth-1:0] r21;
    logic signed [EntryWidth-1:0] r22;
    logic signed [EntryWidth-1:0] r23;
    logic signed [EntryWidth-1:0] r31;
    logic signed [EntryWidth-1:0] r32;
    logic signed [EntryWidth-1:0] r33;
  } out_word_t;

  // one rotator lane state
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
    logic                    flip;
  } lane_t;

  typedef struct packed {
    logic  vld;
    lane_t lx;
    lane_t ly;
    lane_t lz;
  } cell_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [StepIdxW-1:0] i);
    logic signed [CordW-1:0] r;
    case (i)
      5'd0:  r = 36'sh03243F6A8;
      5'd1:  r = 36'sh01DAC6705;
      5'd2:  r = 36'sh00FADBAFC;
      5'd3:  r = 36'sh007F56EA6;
      5'd4:  r = 36'sh003FEAB76;
      5'd5:  r = 36'sh001FFD55B;
      5'd6:  r = 36'sh000FFFAAA;
      5'd7:  r = 36'sh0007FFF55;
      5'd8:  r = 36'sh0003FFFEA;
      5'd9:  r = 36'sh0001FFFFD;
      5'd10: r = 36'sh0000FFFFF;
      5'd11: r = 36'sh00007FFFF;
      5'd12: r = 36'sh00003FFFF;
      5'd13: r = 36'sh00001FFFF;
      5'd14: r = 36'sh00000FFFF;
      5'd15: r = 36'sh000007FFF;
      5'd16: r = 36'sh000003FFF;
      5'd17: r = 36'sh000001FFF;
      5'd18: r = 36'sh000000FFF;
      5'd19: r = 36'sh0000007FF;
      5'd20: r = 36'sh0000003FF;
      5'd21: r = 36'sh0000001FF;
      5'd22: r = 36'sh0000000FF;
      5'd23: r = 36'sh00000007F;
      5'd24: r = 36'sh00000003F;
      5'd25: r = 36'sh00000001F;
      5'd26: r = 36'sh00000000F;
      5'd27: r = 36'sh000000008;
      5'd28: r = 36'sh000000004;
      5'd29: r = 36'sh000000002;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/e2r_cell.sv
`timescale 1ns / 1ps
// one CORDIC micro-rotation for all three angles
module e2r_cell import e2r_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [StepIdxW-1:0] step_i,
  input  cell_t               cell_i,
  output cell_t               cell_o
);

  cell_t cell_d, cell_q;

  function automatic lane_t rot(input lane_t l, input logic [StepIdxW-1:0] i);
    lane_t r;
    logic signed [CordW-1:0] dx, dy, a;
    dx = l.y >>> i;
    dy = l.x >>> i;
    a  = atan_q30(i);
    r  = l;
    if (!l.z[CordW-1]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - a;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + a;
    end
    return r;
  endfunction

  always_comb begin
    cell_d     = cell_i;
    cell_d.lx  = rot(cell_i.lx, step_i);
    cell_d.ly  = rot(cell_i.ly, step_i);
    cell_d.lz  = rot(cell_i.lz, step_i);
  end

  // pipeline register, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/e2r_matrix.sv
`timescale 1ns / 1ps
// product pipeline: sin/cos to nine matrix entries, four register stages
module e2r_matrix import e2r_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  cell_t     cell_i,
  output logic      vld_o,
  output out_word_t word_o
);

  // operands stay below 2.0 in Q30, so 32 bits carry them exactly
  localparam int MulW = 32;
  localparam int PW   = 2 * MulW;

  function automatic logic signed [CordW-1:0] mq(input logic signed [CordW-1:0] a,
                                                 input logic signed [CordW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(signed'(a[MulW-1:0])) * PW'(signed'(b[MulW-1:0])) + (PW'(1) <<< 29);
    return CordW'(p >>> 30);
  endfunction

  function automatic logic signed [EntryWidth-1:0] ent(input logic signed [CordW-1:0] v);
    localparam int Sh = 32 - EntryWidth;
    logic signed [CordW-1:0] r, lim;
    lim = CordW'(1) <<< (EntryWidth - 2);
    r = (v + (CordW'(1) <<< (Sh - 1))) >>> Sh;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return EntryWidth'(r);
  endfunction

  logic signed [CordW-1:0] sx, cx, sy, cy, sz, cz;
  logic [3:0] vld_q;
  // stage 1: sines and cosines after quadrant fix
  logic signed [CordW-1:0] sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  // stage 2: pair products
  logic signed [CordW-1:0] sxsy_q, cxsy_q, p11_q, p12_q, p13_q, p21_q, p22_q,
                           p23_q, p32_q, p33_q, msy_q, sz2_q, cz2_q;
  // stage 3: triple products
  logic signed [CordW-1:0] t12_q, t13_q, t22_q, t23_q, a11_q, a12_q, a13_q, a21_q,
                           a22_q, a23_q, a31_q, a32_q, a33_q;

  always_comb begin
    sx = cell_i.lx.flip ? -cell_i.lx.y : cell_i.lx.y;
    cx = cell_i.lx.flip ? -cell_i.lx.x : cell_i.lx.x;
    sy = cell_i.ly.flip ? -cell_i.ly.y : cell_i.ly.y;
    cy = cell_i.ly.flip ? -cell_i.ly.x : cell_i.ly.x;
    sz = cell_i.lz.flip ? -cell_i.lz.y : cell_i.lz.y;
    cz = cell_i.lz.flip ? -cell_i.lz.x : cell_i.lz.x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], cell_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= sx; cx_q <= cx; sy_q <= sy; cy_q <= cy; sz_q <= sz; cz_q <= cz;
      sxsy_q <= mq(sx_q, sy_q);
      cxsy_q <= mq(cx_q, sy_q);
      p11_q  <= mq(cy_q, cz_q);
      p12_q  <= mq(-cx_q, sz_q);
      p13_q  <= mq(sx_q, sz_q);
      p21_q  <= mq(cy_q, sz_q);
      p22_q  <= mq(cx_q, cz_q);
      p23_q  <= mq(-sx_q, cz_q);
      p32_q  <= mq(sx_q, cy_q);
      p33_q  <= mq(cx_q, cy_q);
      msy_q  <= -sy_q;
      sz2_q  <= sz_q;
      cz2_q  <= cz_q;
      t12_q  <= mq(sxsy_q, cz2_q);
      t13_q  <= mq(cxsy_q, cz2_q);
      t22_q  <= mq(sxsy_q, sz2_q);
      t23_q  <= mq(cxsy_q, sz2_q);
      a11_q <= p11_q; a12_q <= p12_q; a13_q <= p13_q; a21_q <= p21_q;
      a22_q <= p22_q; a23_q <= p23_q; a31_q <= msy_q; a32_q <= p32_q; a33_q <= p33_q;
      word_o.r11 <= ent(a11_q);
      word_o.r12 <= ent(a12_q + t12_q);
      word_o.r13 <= ent(a13_q + t13_q);
      word_o.r21 <= ent(a21_q);
      word_o.r22 <= ent(a22_q + t22_q);
      word_o.r23 <= ent(a23_q + t23_q);
      word_o.r31 <= ent(a31_q);
      word_o.r32 <= ent(a32_q);
      word_o.r33 <= ent(a33_q);
    end
  end

  assign vld_o = vld_q[3];

endmodule

// File: rtl/euler_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Pipeline: 1 reduction register, 30 CORDIC cells and 4 product stages
// lie between input and output word. Throughput: one word per cycle; the
// whole chain advances when the output register is empty or being taken.
// Reset: asynchronous active low, clears all valid bits; the pipe is empty.
module euler_to_rotation_matrix import e2r_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic  en;
  cell_t head_q;
  cell_t chain [CordicSteps+1];

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  function automatic lane_t reduce(input logic signed [AngleWidth-1:0] a);
    lane_t l;
    logic signed [CordW-1:0] t;
    t = CordW'(a) <<< (33 - AngleWidth);
    l.flip = 1'b0;
    if (t > HalfPiQ30) begin
      t = t - PiQ30; l.flip = 1'b1;
    end else if (t < -HalfPiQ30) begin
      t = t + PiQ30; l.flip = 1'b1;
    end
    l.x = GainQ30;
    l.y = '0;
    l.z = t;
    return l;
  endfunction

  // input register with range reduction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (en) begin
      head_q.vld <= in_valid_i;
      head_q.lx  <= reduce(in_data_i.angle_x);
      head_q.ly  <= reduce(in_data_i.angle_y);
      head_q.lz  <= reduce(in_data_i.angle_z);
    end
  end

  assign chain[0] = head_q;

  // CORDIC chain
  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    e2r_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (StepIdxW'(g)),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  e2r_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cell_i (chain[CordicSteps]),
    .vld_o  (out_valid_o),
    .word_o (out_data_o)
  );

endmodule

// File: rtl/e2r_checker.sv
`timescale 1ns / 1ps
module e2r_props import e2r_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("ready low with empty output");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i)) else $error("ready mismatch");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word not held");

  a_r31_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.r31) <= 16384 && $signed(out_data_o.r31) >= -16384))
    else $error("entry out of range");

endmodule

bind euler_to_rotation_matrix e2r_props u_e2r_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
